>>> rtl/core/gfba_pkg.sv
// Grouped free-block allocator: shared widths, defaults, codes and FSM type.
// No dependencies; used by the allocator top level.
package gfba_pkg;

    localparam int STACK_DEPTH = 50;
    localparam int BLOCK_COUNT = 512;

    localparam int BLK_W  = 9;
    localparam int FREE_W = 10;
    localparam logic [FREE_W-1:0] FREE_MAX = '1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_POP    = 5'b00010,
        S_SPILL  = 5'b00100,
        S_REFILL = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

endpackage

>>> rtl/core/gfba_ram.sv
// Generic simple dual-port RAM, one write and one read port, registered read.
// No dependencies.
module gfba_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/core/grouped_free_block_allocator_top.sv
// Grouped free-block allocator top level: stack sequencer and group store.
// Depends on gfba_pkg and gfba_ram.
//
// Allocator for free block numbers kept as an in-core stack with chained
// groups spilled to a group store. One item at a time: the input is stalled
// from acceptance until the result is loaded into the output register, and
// the next item is taken while that result waits. A free that pushes goes
// from idle to done; an allocate that pops passes the pop state (one stack
// RAM read). A free onto a full stack (spill) or an allocate of the last
// entry (refill) copies the whole group through one address counter and the
// RAM ports, one entry per cycle. Block 0 and blocks at or above BLOCK_COUNT
// are ignored on free. The free count saturates at 0 and 1023.
module grouped_free_block_allocator_top #(
    parameter int STACK_DEPTH = gfba_pkg::STACK_DEPTH,
    parameter int BLOCK_COUNT = gfba_pkg::BLOCK_COUNT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_func,
    input  logic [gfba_pkg::BLK_W-1:0]  i_block_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_status,
    output logic [gfba_pkg::BLK_W-1:0]  o_block,
    output logic [gfba_pkg::FREE_W-1:0] o_free_count
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int SAW   = $clog2(BLOCK_COUNT * STACK_DEPTH);
    localparam int BW    = gfba_pkg::BLK_W;
    localparam int FW    = gfba_pkg::FREE_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

    gfba_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [FW-1:0]    r_free, n_free;
    logic [BW-1:0]    r_bottom, n_bottom;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [SAW-1:0]   r_addr, n_addr;
    logic [BW-1:0]    r_blk, n_blk;
    logic             r_stat, n_stat;
    logic             r_out_valid, n_out_valid;
    logic             r_out_status;
    logic [BW-1:0]    r_out_block;
    logic [FW-1:0]    r_out_free;

    logic             w_acc, w_load, w_in_range;
    logic [CNT_W-1:0] w_top;
    logic [BW-1:0]    w_mul_a;
    logic [31:0]      w_prod;
    logic [FW-1:0]    w_free_inc, w_free_dec;

    logic             s_we;
    logic [IDX_W-1:0] s_waddr, s_raddr;
    logic [BW-1:0]    s_wdata, s_rdata;
    logic             g_we;
    logic [BW-1:0]    g_wdata, g_rdata;

    gfba_ram #(.WIDTH(BW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    gfba_ram #(.WIDTH(BW), .DEPTH(BLOCK_COUNT * STACK_DEPTH)) u_group (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (r_addr),
        .i_wdata (g_wdata),
        .i_raddr (r_addr),
        .o_rdata (g_rdata)
    );

    assign w_acc      = (r_state == gfba_pkg::S_IDLE) && i_in_valid;
    assign w_top      = r_count - ONE_C;
    assign w_in_range = 32'(i_block_index) < 32'(BLOCK_COUNT);
    assign w_mul_a    = (i_func == gfba_pkg::FUNC_ALLOC) ? r_bottom : i_block_index;
    assign w_prod     = 32'(w_mul_a) * 32'(STACK_DEPTH);
    assign w_free_inc = (r_free == gfba_pkg::FREE_MAX) ? r_free : r_free + FW'(1);
    assign w_free_dec = (r_free == '0) ? r_free : r_free - FW'(1);
    assign s_raddr    = (r_state == gfba_pkg::S_IDLE) ? w_top[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign w_load     = (r_state == gfba_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    function automatic logic [IDX_W-1:0] w_top_idx(input logic [CNT_W-1:0] idx);
        logic [CNT_W-1:0] prev;
        prev = idx - ONE_C;
        return prev[IDX_W-1:0];
    endfunction

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_free      = r_free;
        n_bottom    = r_bottom;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_blk       = r_blk;
        n_stat      = r_stat;
        n_out_valid = r_out_valid && i_out_stall;
        s_we        = 1'b0;
        s_waddr     = r_count[IDX_W-1:0];
        s_wdata     = i_block_index;
        g_we        = 1'b0;
        g_wdata     = (r_idx == ONE_C) ? r_bottom : s_rdata;
        case (r_state)
            gfba_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_blk  = i_block_index;
                    n_stat = gfba_pkg::STATUS_OK;
                    n_idx  = '0;
                    n_addr = SAW'(w_prod);
                    if (i_func == gfba_pkg::FUNC_ALLOC) begin
                        if (r_count <= ONE_C) begin
                            if (r_bottom == '0) begin
                                n_stat  = gfba_pkg::STATUS_EMPTY;
                                n_blk   = '0;
                                n_state = gfba_pkg::S_DONE;
                            end else begin
                                n_blk   = r_bottom;
                                n_state = gfba_pkg::S_REFILL;
                            end
                        end else begin
                            n_state = gfba_pkg::S_POP;
                        end
                    end else begin
                        if (i_block_index == '0 || !w_in_range) begin
                            n_blk   = '0;
                            n_state = gfba_pkg::S_DONE;
                        end else if (r_count == DEPTH_C) begin
                            n_state = gfba_pkg::S_SPILL;
                        end else begin
                            s_we    = 1'b1;
                            n_count = r_count + ONE_C;
                            n_free  = w_free_inc;
                            n_blk   = '0;
                            n_state = gfba_pkg::S_DONE;
                        end
                    end
                end
            end
            gfba_pkg::S_POP: begin
                n_blk   = s_rdata;
                n_count = w_top;
                n_free  = w_free_dec;
                n_state = gfba_pkg::S_DONE;
            end
            gfba_pkg::S_REFILL: begin
                if (r_idx != DEPTH_C) begin
                    n_addr = r_addr + SAW'(1);
                end
                if (r_idx == ONE_C) begin
                    n_bottom = g_rdata;
                end else if (r_idx != '0) begin
                    s_we    = 1'b1;
                    s_waddr = w_top_idx(r_idx);
                    s_wdata = g_rdata;
                end
                if (r_idx == DEPTH_C) begin
                    n_count = DEPTH_C;
                    n_free  = w_free_dec;
                    n_state = gfba_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + ONE_C;
                end
            end
            gfba_pkg::S_SPILL: begin
                if (r_idx != '0) begin
                    g_we   = 1'b1;
                    n_addr = r_addr + SAW'(1);
                end
                if (r_idx == DEPTH_C) begin
                    n_bottom = r_blk;
                    n_count  = ONE_C;
                    n_free   = w_free_inc;
                    n_blk    = '0;
                    n_state  = gfba_pkg::S_DONE;
                end else begin
                    n_idx = r_idx + ONE_C;
                end
            end
            gfba_pkg::S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = gfba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gfba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gfba_pkg::S_IDLE;
            r_count     <= ONE_C;
            r_free      <= '0;
            r_bottom    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_free      <= n_free;
            r_bottom    <= n_bottom;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_addr <= n_addr;
        r_blk  <= n_blk;
        r_stat <= n_stat;
        if (w_load) begin
            r_out_status <= r_stat;
            r_out_block  <= r_blk;
            r_out_free   <= r_free;
        end
    end

    assign o_in_stall   = (r_state != gfba_pkg::S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_block      = r_out_block;
    assign o_free_count = r_out_free;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= ONE_C) && (r_count <= DEPTH_C))
        else $error("stack count out of range");

    a_refill_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gfba_pkg::S_REFILL) |-> (r_blk != '0))
        else $error("refill from end marker");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gfba_pkg::S_POP) |-> (r_count > ONE_C))
        else $error("pop with only bottom entry");

    a_spill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == gfba_pkg::S_SPILL) && (r_idx == DEPTH_C))
        |=> ((r_count == ONE_C) && (r_bottom == $past(r_blk))))
        else $error("spill did not reset stack");
`endif

endmodule

>>> bench/tb_grouped_free_block_allocator_top.sv
`timescale 1ns / 100ps
// Self-checking bench for grouped_free_block_allocator_top: directed, spill/refill, hold-off,
// random and saturation tests against an in-bench mirror of the allocator state.
// Depends on gfba_pkg and the allocator RTL.
module tb_grouped_free_block_allocator_top;

    localparam int STACK_DEPTH     = gfba_pkg::STACK_DEPTH;
    localparam int BLOCK_COUNT     = gfba_pkg::BLOCK_COUNT;
    localparam int BLK_W           = gfba_pkg::BLK_W;
    localparam int FREE_W          = gfba_pkg::FREE_W;
    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 7;
    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 60;
    localparam int RANDOM_ITEMS    = 80;
    localparam int SAT_EXTRA       = 4;
    localparam int TAIL_ALLOCS     = 20;
    localparam int STORE_DEPTH     = BLOCK_COUNT * STACK_DEPTH;

    typedef struct packed {
        logic              status;
        logic [BLK_W-1:0]  block;
        logic [FREE_W-1:0] free_count;
    } t_alloc_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_func;
    logic [BLK_W-1:0]  i_block_index;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_status;
    logic [BLK_W-1:0]  o_block;
    logic [FREE_W-1:0] o_free_count;

    // mirror of the allocator
    logic [BLK_W-1:0]  free_stack [STACK_DEPTH];
    logic [BLK_W-1:0]  group_copy [STORE_DEPTH];
    int                stack_fill;
    logic [FREE_W-1:0] free_tally;
    int                chain_blocks;

    t_alloc_result     expected_results [$];
    int                error_count;
    int                idle_cycles;
    logic              quiet;
    logic              hold_req;

    grouped_free_block_allocator_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_block_index (i_block_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_block       (o_block),
        .o_free_count  (o_free_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    function automatic t_alloc_result predict_block_op(input logic fn,
                                                       input logic [BLK_W-1:0] idx);
        t_alloc_result res;
        int            base;
        res.status = gfba_pkg::STATUS_OK;
        res.block  = '0;
        if (fn == gfba_pkg::FUNC_ALLOC) begin
            if (stack_fill <= 1) begin
                if (free_stack[0] == '0) begin
                    res.status     = gfba_pkg::STATUS_EMPTY;
                    res.free_count = free_tally;
                    return res;
                end
                res.block = free_stack[0];
                base = int'(free_stack[0]) * STACK_DEPTH;
                for (int i = 0; i < STACK_DEPTH; i++) free_stack[i] = group_copy[base + i];
                stack_fill = STACK_DEPTH;
            end else begin
                stack_fill = stack_fill - 1;
                res.block  = free_stack[stack_fill];
            end
            if (free_tally != '0) free_tally = free_tally - FREE_W'(1);
            chain_blocks = chain_blocks - 1;
        end else if (idx != '0 && int'(idx) < BLOCK_COUNT) begin
            if (stack_fill >= STACK_DEPTH) begin
                base = int'(idx) * STACK_DEPTH;
                for (int i = 0; i < STACK_DEPTH; i++) group_copy[base + i] = free_stack[i];
                free_stack[0] = idx;
                stack_fill    = 1;
            end else begin
                free_stack[stack_fill] = idx;
                stack_fill = stack_fill + 1;
            end
            if (free_tally != gfba_pkg::FREE_MAX) free_tally = free_tally + FREE_W'(1);
            chain_blocks = chain_blocks + 1;
        end
        res.free_count = free_tally;
        return res;
    endfunction

    task automatic send_op(input logic fn, input logic [BLK_W-1:0] idx);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 16);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= fn;
        i_block_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_results.push_back(predict_block_op(fn, idx));
    endtask

    task automatic check_field(input string name, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected, actual);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_alloc_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, %s %0d block %0d count %0d",
                         $time, "actual status", o_status, o_block, o_free_count);
                error_count++;
            end else begin
                exp_res = expected_results.pop_front();
                check_field("status", 32'(exp_res.status), 32'(o_status));
                check_field("block", 32'(exp_res.block), 32'(o_block));
                check_field("free_count", 32'(exp_res.free_count), 32'(o_free_count));
            end
        end
    end

    // result side: random stall bursts, a long hold-off on request, none when quiet
    initial begin
        int   run_len;
        int   hold_left;
        logic stall_level;
        logic hold_taken;
        i_out_stall = 1'b0;
        run_len     = 0;
        hold_left   = 0;
        stall_level = 1'b0;
        hold_taken  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
                run_len    = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
            end else begin
                if (run_len == 0) begin
                    stall_level = ($urandom_range(0, 2) == 0);
                    run_len     = stall_level ? $urandom_range(1, 16) : $urandom_range(1, 48);
                end
                run_len--;
                i_out_stall <= stall_level;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_directed_cases;
        send_op(gfba_pkg::FUNC_ALLOC, '0);
        send_op(gfba_pkg::FUNC_FREE, '0);
        send_op(gfba_pkg::FUNC_FREE, 9'd511);
        send_op(gfba_pkg::FUNC_FREE, 9'd1);
        send_op(gfba_pkg::FUNC_FREE, 9'd1);
        send_op(gfba_pkg::FUNC_FREE, 9'h155);
        send_op(gfba_pkg::FUNC_FREE, 9'h0AA);
        send_op(gfba_pkg::FUNC_ALLOC, 9'h1FF);
        send_op(gfba_pkg::FUNC_FREE, '0);
        repeat (6) send_op(gfba_pkg::FUNC_ALLOC, BLK_W'($urandom_range(0, 511)));
        send_op(gfba_pkg::FUNC_FREE, 9'h100);
        send_op(gfba_pkg::FUNC_ALLOC, '0);
        send_op(gfba_pkg::FUNC_ALLOC, '0);
    endtask

    // two spills, then allocate through both refills and past empty
    task automatic test_spill_and_refill;
        repeat (2 * STACK_DEPTH + 10)
            send_op(gfba_pkg::FUNC_FREE, BLK_W'($urandom_range(1, BLOCK_COUNT - 1)));
        while (chain_blocks > 0) send_op(gfba_pkg::FUNC_ALLOC, BLK_W'($urandom_range(0, 511)));
        repeat (2) send_op(gfba_pkg::FUNC_ALLOC, BLK_W'($urandom_range(0, 511)));
    endtask

    task automatic test_output_hold_off;
        hold_req <= 1'b1;
        repeat (8) send_op(1'($urandom_range(0, 1)), BLK_W'($urandom_range(0, 511)));
    endtask

    task automatic test_random_traffic;
        int sent;
        int burst;
        int kind;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 60);
            kind  = $urandom_range(0, 9);
            for (int k = 0; k < burst; k++) begin
                if (kind < 4)
                    send_op(gfba_pkg::FUNC_FREE, BLK_W'($urandom_range(1, BLOCK_COUNT - 1)));
                else if (kind < 8)
                    send_op(gfba_pkg::FUNC_ALLOC, BLK_W'($urandom_range(0, 511)));
                else
                    send_op(1'($urandom_range(0, 1)),
                            ($urandom_range(0, 7) == 0) ? BLK_W'(0)
                                                        : BLK_W'($urandom_range(0, 511)));
            end
            sent += burst;
        end
    endtask

    // push the count to its top and past it, then allocate a few; no idling from here on
    task automatic test_count_saturation;
        quiet <= 1'b1;
        while (free_tally != gfba_pkg::FREE_MAX)
            send_op(gfba_pkg::FUNC_FREE, BLK_W'($urandom_range(1, BLOCK_COUNT - 1)));
        repeat (SAT_EXTRA)
            send_op(gfba_pkg::FUNC_FREE, BLK_W'($urandom_range(1, BLOCK_COUNT - 1)));
        repeat (TAIL_ALLOCS) send_op(gfba_pkg::FUNC_ALLOC, BLK_W'($urandom_range(0, 511)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_func        = gfba_pkg::FUNC_ALLOC;
        i_block_index = '0;
        quiet         = 1'b0;
        hold_req      = 1'b0;
        for (int i = 0; i < STACK_DEPTH; i++) free_stack[i] = '0;
        stack_fill   = 1;
        free_tally   = '0;
        chain_blocks = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cases();
        test_spill_and_refill();
        test_output_hold_off();
        test_random_traffic();
        test_count_saturation();

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
